// ----- rtl/stks_pkg.sv -----
// Shared types and constants for the streaming top-k selection block.
// No dependencies; imported by stks_cell, streaming_top_k_selection and tb_top.
package stks_pkg;

  localparam int SCORE_W = 32;
  localparam int INDEX_W = 18;
  localparam int KCFG_W  = 5;
  // wide enough for any cell number and any written count
  localparam int KCMP_W  = 7;

  localparam logic [KCFG_W-1:0] KEEP_COUNT_RESET = 5'd16;
  localparam logic              REG_KEEP_COUNT   = 1'b0;

  typedef enum logic {
    COLLECT,
    DRAIN
  } state_t;

  typedef struct packed {
    logic insert;     // an input beat is taken this cycle
    logic shift_out;  // an output beat is taken; move entries toward cell 0
  } ctrl_t;

endpackage

// ----- rtl/stks_cell.sv -----
// One slot of the sorted store: score, index and valid flag.
// Depends on stks_pkg; a row of these forms streaming_top_k_selection.
module stks_cell
  import stks_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  ctrl_t                     ctrl,
  input  logic                      active,
  input  logic signed [SCORE_W-1:0] new_score,
  input  logic [INDEX_W-1:0]        new_index,
  input  logic                      up_beat,
  input  logic signed [SCORE_W-1:0] up_score,
  input  logic [INDEX_W-1:0]        up_index,
  input  logic                      up_valid,
  input  logic signed [SCORE_W-1:0] down_score,
  input  logic [INDEX_W-1:0]        down_index,
  input  logic                      down_valid,
  output logic                      beat,
  output logic signed [SCORE_W-1:0] score,
  output logic [INDEX_W-1:0]        index,
  output logic                      valid,
  output logic                      valid_eff
);

  logic signed [SCORE_W-1:0] score_next;
  logic [INDEX_W-1:0]        index_next;
  logic                      valid_next;

  assign valid_eff = valid && active;
  // equal scores rank below the kept one
  assign beat      = !valid_eff || (new_score > score);

  always_comb begin
    score_next = score;
    index_next = index;
    valid_next = valid;
    if (ctrl.shift_out) begin
      score_next = down_score;
      index_next = down_index;
      valid_next = down_valid;
    end else if (ctrl.insert) begin
      if (!active) begin
        valid_next = 1'b0;
      end else if (up_beat) begin
        score_next = up_score;
        index_next = up_index;
        valid_next = up_valid;
      end else if (beat) begin
        score_next = new_score;
        index_next = new_index;
        valid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    score <= score_next;
    index <= index_next;
  end

endmodule

// ----- rtl/streaming_top_k_selection.sv -----
// Top level of the streaming top-k selection block: row of stks_cell slots,
// position counter, drain control and APB register. Depends on stks_pkg.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------------
//   input    | in_valid / in_stall   | score, last_score
//   output   | out_valid / out_stall | token_index, token_score, last_result
//   config   | psel/penable/pwrite   | paddr, pwdata, prdata (keep_count)
//
// While a vector streams in, one score is taken every cycle: every cell
// compares against the new score in parallel and the row shifts by one.
// After the beat marked last, in_stall stays high while the kept pairs shift
// out of cell 0, one per output beat. Output stalls simply hold the row. Reset
// clears the valid flags, the position counter and sets keep_count to 16; no
// clearing pass is needed.
module streaming_top_k_selection
  import stks_pkg::*;
#(
  parameter int MAX_KEEP  = 16,
  parameter int MAX_ITEMS = 262144
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [SCORE_W-1:0] score,
  input  logic                      last_score,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [INDEX_W-1:0]        token_index,
  output logic signed [SCORE_W-1:0] token_score,
  output logic                      last_result,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int POS_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  state_t state, state_next;
  ctrl_t  ctrl;

  logic [KCFG_W-1:0] keep_count;
  logic [KCMP_W-1:0] keep_eff;
  logic [POS_W-1:0]  position, position_next;
  logic [POS_W+INDEX_W-1:0] pos_wide;
  logic [INDEX_W-1:0] cur_index;

  logic in_take, out_take;

  logic signed [SCORE_W-1:0] cell_score [MAX_KEEP+1];
  logic [INDEX_W-1:0]        cell_index [MAX_KEEP+1];
  logic [MAX_KEEP:0]         cell_valid;
  logic [MAX_KEEP-1:0]       cell_veff;
  logic [MAX_KEEP-1:0]       cell_beat;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KEEP_COUNT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_KEEP_COUNT) begin
      keep_count <= pwdata[KCFG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_KEEP_COUNT) ? {{(32-KCFG_W){1'b0}}, keep_count} : 32'd0;

  // zero acts as one; counts above the row length fall off its end
  assign keep_eff = (keep_count == '0) ? KCMP_W'(1) : KCMP_W'(keep_count);

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  assign ctrl = '{insert: in_take, shift_out: out_take};

  // position counter
  always_comb begin
    position_next = position;
    if (in_take) begin
      if (last_score || position == POS_W'(MAX_ITEMS - 1)) begin
        position_next = '0;
      end else begin
        position_next = position + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else begin
      position <= position_next;
    end
  end

  assign pos_wide  = {{INDEX_W{1'b0}}, position};
  assign cur_index = pos_wide[INDEX_W-1:0];

  // row of cells; the slot past the end feeds an empty entry during drain
  assign cell_score[MAX_KEEP]  = '0;
  assign cell_index[MAX_KEEP]  = '0;
  assign cell_valid[MAX_KEEP]  = 1'b0;

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    logic up_beat;
    logic signed [SCORE_W-1:0] up_score;
    logic [INDEX_W-1:0] up_index;
    logic up_valid;

    if (i == 0) begin : g_head
      assign up_beat  = 1'b0;
      assign up_score = '0;
      assign up_index = '0;
      assign up_valid = 1'b0;
    end else begin : g_body
      assign up_beat  = cell_beat[i-1];
      assign up_score = cell_score[i-1];
      assign up_index = cell_index[i-1];
      assign up_valid = cell_veff[i-1];
    end

    stks_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .active     (KCMP_W'(i) < keep_eff),
      .new_score  (score),
      .new_index  (cur_index),
      .up_beat    (up_beat),
      .up_score   (up_score),
      .up_index   (up_index),
      .up_valid   (up_valid),
      .down_score (cell_score[i+1]),
      .down_index (cell_index[i+1]),
      .down_valid (cell_valid[i+1]),
      .beat       (cell_beat[i]),
      .score      (cell_score[i]),
      .index      (cell_index[i]),
      .valid      (cell_valid[i]),
      .valid_eff  (cell_veff[i])
    );
  end

  // control
  always_comb begin
    state_next = state;
    case (state)
      COLLECT: if (in_take && last_score) state_next = DRAIN;
      DRAIN:   if (out_take && last_result) state_next = COLLECT;
      default: state_next = COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    in_stall  = 1'b0;
    out_valid = 1'b0;
    case (state)
      COLLECT: begin
        in_stall  = 1'b0;
        out_valid = 1'b0;
      end
      DRAIN: begin
        in_stall  = 1'b1;
        out_valid = 1'b1;
      end
      default: begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
      end
    endcase
  end

  assign token_score = cell_score[0];
  assign token_index = cell_index[0];
  assign last_result = !cell_valid[1];

  // checks
  a_drain_has_entry: assert property (@(posedge clk) disable iff (rst)
    state == DRAIN |-> cell_valid[0])
    else $error("drain with empty head cell");

  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    (cell_valid & (cell_valid + 1'b1)) == '0)
    else $error("valid entries not packed toward cell 0");

  a_last_starts_drain: assert property (@(posedge clk) disable iff (rst)
    in_take && last_score |=> state == DRAIN && out_valid)
    else $error("last beat did not start the report");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    out_take && last_result |=> cell_valid == '0 && position == '0)
    else $error("store not empty after report");

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for streaming_top_k_selection: a table of directed beats,
// then random vectors, all checked by a top-k predictor.
// Depends on stks_pkg and the streaming_top_k_selection RTL.
module tb_top
  import stks_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEEP_DEPTH   = 16;
  localparam int RANDOM_ITEMS = 140;
  localparam int SETTLE       = 8;
  localparam int QUIET_LIMIT  = 2000;
  localparam logic [2:0] ADDR_KEEP_COUNT = 3'(4 * int'(REG_KEEP_COUNT));

  typedef enum int {
    SC_FULL,
    SC_TIES,
    SC_EDGES,
    SC_NARROW
  } score_mix_t;

  typedef struct packed {
    logic [INDEX_W-1:0]        idx;
    logic signed [SCORE_W-1:0] sc;
    logic                      fin;
  } pair_t;

  typedef struct packed {
    logic                      set_k;
    logic [KCFG_W-1:0]         k;
    logic signed [SCORE_W-1:0] sc;
    logic                      lst;
    logic                      typed;
    pair_t                     want;
  } dir_row_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [SCORE_W-1:0] score;
  logic                      last_score;
  logic                      out_valid;
  logic                      out_stall;
  logic [INDEX_W-1:0]        token_index;
  logic signed [SCORE_W-1:0] token_score;
  logic                      last_result;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [2:0]                paddr;
  logic [31:0]               pwdata;
  logic [31:0]               prdata;
  logic                      pready;

  streaming_top_k_selection u_dut (.*);

  // top-k predictor state
  logic signed [SCORE_W-1:0] kept_sc [KEEP_DEPTH];
  logic [INDEX_W-1:0]        kept_ix [KEEP_DEPTH];
  int                        kept_n = 0;
  logic [INDEX_W-1:0]        next_pos = '0;
  logic [KCFG_W-1:0]         keep_reg = KEEP_COUNT_RESET;
  pair_t                     pending_pairs[$];

  logic  send_calm = 1'b0;
  logic  drain_calm = 1'b0;
  logic  typed_on = 1'b0;
  pair_t typed_want;
  int    errors = 0;
  int    quiet = 0;
  int    scores_in = 0;
  int    pairs_out = 0;
  int    vectors_done = 0;
  int    cfg_writes = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_error(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Insert one score into the sorted store; on the last score emit the ranked pairs.
  task automatic rank_score(input logic signed [SCORE_W-1:0] s, input logic lst);
    int    k;
    int    slot;
    int    j;
    pair_t p;
    k = (keep_reg == 0) ? 1 : ((keep_reg > KEEP_DEPTH) ? KEEP_DEPTH : int'(keep_reg));
    if (kept_n > k) kept_n = k;
    // first entry strictly below the new score; equal scores rank above it
    slot = kept_n;
    for (j = kept_n - 1; j >= 0; j--) begin
      if (kept_sc[j] < s) slot = j;
    end
    if (slot < k) begin
      if (kept_n < k) kept_n++;
      for (j = kept_n - 1; j > slot; j--) begin
        kept_sc[j] = kept_sc[j-1];
        kept_ix[j] = kept_ix[j-1];
      end
      kept_sc[slot] = s;
      kept_ix[slot] = next_pos;
    end
    // index width matches the item limit, so the counter wraps by itself
    next_pos++;
    if (lst) begin
      for (j = 0; j < kept_n; j++) begin
        p.idx = kept_ix[j];
        p.sc  = kept_sc[j];
        p.fin = (j == kept_n - 1);
        pending_pairs = {pending_pairs, p};
      end
      kept_n   = 0;
      next_pos = '0;
    end
  endtask

  function automatic logic [KCFG_W-1:0] pick_keep();
    case ($urandom_range(0, 5))
      0: return KCFG_W'(1);
      1: return KCFG_W'(KEEP_DEPTH);
      2: return KCFG_W'(0);
      3: return KCFG_W'($urandom_range(KEEP_DEPTH + 1, 31));
      default: return KCFG_W'($urandom_range(1, KEEP_DEPTH));
    endcase
  endfunction

  function automatic logic signed [SCORE_W-1:0] draw_score(input score_mix_t mix);
    logic [SCORE_W-1:0] r;
    r = $urandom;
    case (mix)
      SC_TIES:   return $signed($urandom_range(0, 6)) - 32'sd3;
      SC_NARROW: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      SC_EDGES: begin
        case (r[1:0])
          2'd0: return 32'sh7FFFFFFF;
          2'd1: return 32'sh80000000;
          2'd2: return '0;
          default: return '1;
        endcase
      end
      default: return r;
    endcase
  endfunction

  // Drop valid and hold off until every ranked pair has been delivered.
  task automatic await_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_pairs.size() != 0);
  endtask

  task automatic send_score(input logic signed [SCORE_W-1:0] s, input logic lst);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    score      <= s;
    last_score <= lst;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  // Write keep_count once no ranked pairs are pending, then read it back.
  task automatic write_keep_count(input logic [KCFG_W-1:0] val);
    logic [31:0] readback;
    await_drain();
    repeat (SETTLE) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_KEEP_COUNT;
    pwdata  <= {(32 - KCFG_W)'($urandom), val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    keep_reg = val;
    cfg_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[KCFG_W-1:0] !== val)
      flag_error($sformatf("keep_count read %0d, wrote %0d", readback[KCFG_W-1:0], val));
  endtask

  // Output side: check each accepted beat, rank each accepted input beat, run the watchdog.
  always @(posedge clk) begin
    pair_t want;
    int    q_base;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        pairs_out++;
        if (pending_pairs.size() == 0) begin
          flag_error($sformatf("unexpected pair index %0d score %0d",
                               token_index, token_score));
        end else begin
          want = pending_pairs.pop_front();
          if (token_index !== want.idx)
            flag_error($sformatf("token_index %0d, expected %0d", token_index, want.idx));
          if (token_score !== want.sc)
            flag_error($sformatf("token_score %0d, expected %0d", token_score, want.sc));
          if (last_result !== want.fin)
            flag_error($sformatf("last_result %b, expected %b", last_result, want.fin));
        end
      end
      if (in_valid && !in_stall) begin
        scores_in++;
        q_base = pending_pairs.size();
        rank_score(score, last_score);
        if (last_score) vectors_done++;
        // hand-typed first pair replaces the predicted one
        if (typed_on && last_score) pending_pairs[q_base] = typed_want;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("watchdog: %0d idle cycles, %0d pairs pending", quiet, pending_pairs.size());
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  // Receiver: stall after some beats, and now and then while nothing is offered.
  initial begin
    int gap;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if ((out_valid && !out_stall) || (!out_valid && $urandom_range(0, 7) == 0)) begin
        if ($urandom_range(0, 31) == 0) drain_calm = !drain_calm;
        gap = drain_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
          @(negedge clk);
          out_stall <= 1'b1;
          repeat (gap) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    dir_row_t   rows [20];
    score_mix_t mix;
    int len;
    int n;
    int rand_items;

    rows = '{
      // single-score vectors at both extremes
      '{1'b0, 5'd0,  32'sh7FFFFFFF, 1'b1, 1'b1, '{18'd0, 32'sh7FFFFFFF, 1'b1}},
      '{1'b0, 5'd0,  32'sh80000000, 1'b1, 1'b1, '{18'd0, 32'sh80000000, 1'b1}},
      // fewer scores than the count, with a tie
      '{1'b0, 5'd0,  32'sd3,        1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  -32'sd7,       1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  32'sd3,        1'b1, 1'b1, '{18'd0, 32'sd3, 1'b0}},
      // count of zero keeps one; a later equal score does not displace it
      '{1'b1, 5'd0,  32'sd10,       1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  32'sd20,       1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  32'sd20,       1'b1, 1'b1, '{18'd1, 32'sd20, 1'b1}},
      // count above the store depth
      '{1'b1, 5'd31, -32'sd1,       1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  32'sd0,        1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  32'sh7FFFFFFF, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  32'sh80000000, 1'b1, 1'b1, '{18'd2, 32'sh7FFFFFFF, 1'b0}},
      // count cut from 16 to 2 in the middle of a vector
      '{1'b1, 5'd16, 32'sd1,        1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  32'sd2,        1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  32'sd3,        1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  32'sd4,        1'b0, 1'b0, '0},
      '{1'b1, 5'd2,  32'sd0,        1'b1, 1'b1, '{18'd3, 32'sd4, 1'b0}},
      // full store of equal scores: the lower indices stay
      '{1'b0, 5'd0,  32'sd5,        1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  32'sd5,        1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  32'sd5,        1'b1, 1'b1, '{18'd0, 32'sd5, 1'b0}}
    };

    rst        = 1'b1;
    in_valid   = 1'b0;
    score      = '0;
    last_score = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[r]) begin
      if (rows[r].set_k) write_keep_count(rows[r].k);
      typed_on   = rows[r].typed;
      typed_want = rows[r].want;
      send_score(rows[r].sc, rows[r].lst);
    end
    typed_on = 1'b0;

    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0, 1: write_keep_count(pick_keep());
        2: await_drain();
        default: ;
      endcase
      send_calm = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      mix = score_mix_t'($urandom_range(0, 3));
      for (n = 0; n < len; n++) begin
        if (n == len / 2 && n > 0 && $urandom_range(0, 7) == 0)
          write_keep_count(pick_keep());
        send_score(draw_score(mix), n == len - 1);
      end
      rand_items += len;
    end

    await_drain();
    repeat (20) @(negedge clk);
    $display("Run: %0d vectors, %0d scores in, %0d ranked pairs out, %0d keep_count writes",
             vectors_done, scores_in, pairs_out, cfg_writes);
    $display("Covered ties, extreme scores, counts of 0 and above 16, mid-vector count cuts");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/stks_pkg.sv
rtl/stks_cell.sv
rtl/streaming_top_k_selection.sv
dv/tb_top.sv
